// ===== design/ilt_pkg.sv =====
package ilt_pkg;

  // fixed field widths
  localparam int unsigned CONN_ID_W    = 6;
  localparam int unsigned IDLE_LIMIT_W = 16;

  // idle limit after reset, in ticks
  localparam logic [IDLE_LIMIT_W-1:0] IDLE_LIMIT_RST = 16'd10;

  // item operations
  typedef enum logic [1:0] {
    OP_CONNECT    = 2'd0,
    OP_MESSAGE    = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_TICK       = 2'd3
  } opcode_e;

  // field write enables of the link memory
  typedef struct packed {
    logic next;
    logic prev;
  } link_we_t;

endpackage

// ===== design/ilt_link_mem.sv =====
module ilt_link_mem import ilt_pkg::*; #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned PTR_W  = 7
) (
  input  logic              clk_i,
  input  link_we_t          we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [PTR_W-1:0]  wnext_i,
  input  logic [PTR_W-1:0]  wprev_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [PTR_W-1:0]  rnext_o,
  output logic [PTR_W-1:0]  rprev_o
);

  // one word per entry: next link in the upper field, prev link in the lower
  logic [2*PTR_W-1:0] mem [DEPTH];
  logic [2*PTR_W-1:0] rdata_q;

  // masked write, one address per cycle
  always_ff @(posedge clk_i) begin
    if (we_i.next) begin
      mem[waddr_i][2*PTR_W-1:PTR_W] <= wnext_i;
    end
    if (we_i.prev) begin
      mem[waddr_i][PTR_W-1:0] <= wprev_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rnext_o = rdata_q[2*PTR_W-1:PTR_W];
  assign rprev_o = rdata_q[PTR_W-1:0];

endmodule

// ===== design/ilt_stamp_mem.sv =====
module ilt_stamp_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned TIME_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [TIME_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [TIME_W-1:0] rdata_o
);

  logic [TIME_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== design/ilt_ctrl.sv =====
module ilt_ctrl import ilt_pkg::*; #(
  parameter int unsigned MAX_CONN = 64,
  parameter int unsigned ADDR_W   = 6,
  parameter int unsigned PTR_W    = 7,
  parameter int unsigned TIME_W   = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              opcode_i,
  input  logic [CONN_ID_W-1:0]    conn_id_i,
  output logic                    busy_o,
  input  logic [IDLE_LIMIT_W-1:0] idle_limit_i,
  // link memory
  output link_we_t                link_we_o,
  output logic [ADDR_W-1:0]       link_waddr_o,
  output logic [PTR_W-1:0]        link_wnext_o,
  output logic [PTR_W-1:0]        link_wprev_o,
  output logic [ADDR_W-1:0]       raddr_o,
  input  logic [PTR_W-1:0]        link_rnext_i,
  input  logic [PTR_W-1:0]        link_rprev_i,
  // stamp memory
  output logic                    stamp_we_o,
  output logic [TIME_W-1:0]       stamp_wdata_o,
  input  logic [TIME_W-1:0]       stamp_rdata_i,
  // close requests
  output logic                    close_valid_o,
  output logic [CONN_ID_W-1:0]    close_id_o,
  output logic                    last_o
);

  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_CONN);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_UL_RD    = 7'b0000010,
    S_UL_PREV  = 7'b0000100,
    S_APP_SELF = 7'b0001000,
    S_APP_TAIL = 7'b0010000,
    S_SCAN_RD  = 7'b0100000,
    S_SCAN_EV  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  opcode_e             op_q, op_d;
  logic [ADDR_W-1:0]   cid_q, cid_d;
  logic [PTR_W-1:0]    p_q, p_d, n_q, n_d;
  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [PTR_W-1:0]    cur_q, cur_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic [MAX_CONN-1:0] in_list_q, in_list_d;
  logic [MAX_CONN-1:0] closing_q, closing_d;
  logic                pend_vld_q, pend_vld_d;
  logic [ADDR_W-1:0]   pend_q, pend_d;
  logic                out_vld_q, out_vld_d;
  logic [ADDR_W-1:0]   out_id_q, out_id_d;
  logic                out_last_q, out_last_d;

  logic                accept;
  logic                id_ok;
  logic [ADDR_W-1:0]   in_idx;
  logic [ADDR_W-1:0]   cur_idx;
  logic [TIME_W-1:0]   age;
  logic                expired;

  assign busy_o  = (state_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign id_ok   = ({1'b0, conn_id_i} < (CONN_ID_W + 1)'(MAX_CONN));
  assign in_idx  = conn_id_i[ADDR_W-1:0];
  assign cur_idx = cur_q[ADDR_W-1:0];

  // age with wrap against the idle limit
  assign age     = time_q - stamp_rdata_i;
  assign expired = (age > TIME_W'(idle_limit_i));

  // stamp writes always target the item's own entry
  assign stamp_wdata_o = time_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cid_d      = cid_q;
    p_d        = p_q;
    n_d        = n_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cur_d      = cur_q;
    time_d     = time_q;
    in_list_d  = in_list_q;
    closing_d  = closing_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = 1'b0;
    out_id_d   = out_id_q;
    out_last_d = out_last_q;

    link_we_o    = '0;
    link_waddr_o = cid_q;
    link_wnext_o = NIL;
    link_wprev_o = NIL;
    stamp_we_o   = 1'b0;
    raddr_o      = cid_q;

    unique case (state_q)
      S_IDLE: begin
        raddr_o = in_idx;
        if (accept) begin
          op_d  = opcode_e'(opcode_i);
          cid_d = in_idx;
          if (opcode_e'(opcode_i) == OP_TICK) begin
            time_d     = time_q + TIME_W'(1);
            cur_d      = head_q;
            pend_vld_d = 1'b0;
            state_d    = S_SCAN_RD;
          end else if (id_ok) begin
            if (in_list_q[in_idx]) begin
              state_d = S_UL_RD;
            end else if (opcode_e'(opcode_i) == OP_CONNECT) begin
              in_list_d[in_idx] = 1'b1;
              closing_d[in_idx] = 1'b0;
              state_d           = S_APP_SELF;
            end
          end
        end
      end

      // links of the entry are here: bypass it from the predecessor side
      S_UL_RD: begin
        p_d = link_rprev_i;
        n_d = link_rnext_i;
        if (link_rprev_i != NIL) begin
          link_we_o.next = 1'b1;
          link_waddr_o   = link_rprev_i[ADDR_W-1:0];
          link_wnext_o   = link_rnext_i;
        end else begin
          head_d = link_rnext_i;
        end
        state_d = S_UL_PREV;
      end

      // bypass from the successor side
      S_UL_PREV: begin
        if (n_q != NIL) begin
          link_we_o.prev = 1'b1;
          link_waddr_o   = n_q[ADDR_W-1:0];
          link_wprev_o   = p_q;
        end else begin
          tail_d = p_q;
        end
        if (op_q == OP_DISCONNECT) begin
          in_list_d[cid_q] = 1'b0;
          closing_d[cid_q] = 1'b0;
          state_d          = S_IDLE;
        end else begin
          state_d = S_APP_SELF;
        end
      end

      // entry becomes the new tail, stamped now
      S_APP_SELF: begin
        link_we_o.next = 1'b1;
        link_we_o.prev = 1'b1;
        link_waddr_o   = cid_q;
        link_wnext_o   = NIL;
        link_wprev_o   = tail_q;
        stamp_we_o     = 1'b1;
        state_d        = S_APP_TAIL;
      end

      S_APP_TAIL: begin
        if (tail_q != NIL) begin
          link_we_o.next = 1'b1;
          link_waddr_o   = tail_q[ADDR_W-1:0];
          link_wnext_o   = PTR_W'(cid_q);
        end else begin
          head_d = PTR_W'(cid_q);
        end
        tail_d  = PTR_W'(cid_q);
        state_d = S_IDLE;
      end

      // fetch the current entry, or end the scan at the list end
      S_SCAN_RD: begin
        raddr_o = cur_idx;
        if (cur_q == NIL) begin
          out_vld_d  = pend_vld_q;
          out_id_d   = pend_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end else begin
          state_d = S_SCAN_EV;
        end
      end

      // judge the entry; a held request goes out once a later one exists or the scan ends
      S_SCAN_EV: begin
        raddr_o = cur_idx;
        if (!expired) begin
          out_vld_d  = pend_vld_q;
          out_id_d   = pend_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end else begin
          if (!closing_q[cur_idx]) begin
            closing_d[cur_idx] = 1'b1;
            out_vld_d          = pend_vld_q;
            out_id_d           = pend_q;
            out_last_d         = 1'b0;
            pend_vld_d         = 1'b1;
            pend_d             = cur_idx;
          end
          cur_d   = link_rnext_i;
          state_d = S_SCAN_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= NIL;
      tail_q     <= NIL;
      time_q     <= '0;
      in_list_q  <= '0;
      closing_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      time_q     <= time_d;
      in_list_q  <= in_list_d;
      closing_q  <= closing_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cid_q      <= cid_d;
    p_q        <= p_d;
    n_q        <= n_d;
    cur_q      <= cur_d;
    pend_q     <= pend_d;
    out_id_q   <= out_id_d;
    out_last_q <= out_last_d;
  end

  assign close_valid_o = out_vld_q;
  assign close_id_o    = CONN_ID_W'(out_id_q);
  assign last_o        = out_last_q;

endmodule

// ===== design/idle_connection_lru_timeout.sv =====
// channel    | direction | signals                          | handshake
// -----------+-----------+----------------------------------+-----------------------------
// command    | in        | opcode_i, conn_id_i              | start_i high, busy_o low
// close req  | out       | close_id_o, last_o               | close_valid_o, one cycle
// config     | in        | cfg_wdata_i (idle limit)         | cfg_we_i, taken at once
//
// Once accepted, busy_o stays high while the sequencer unlinks for a disconnect, appends
// for a new id's connect, unlinks and appends for a present id's connect or message, or
// walks a tick over idle entries from the head to a fresh one or off the tail.
// Ignored commands leave it low; one link write port and a registered read set the pace.
// Reset empties the list and clears the clock; link and stamp memories need no clearing.
// Close requests carry no back-pressure: each is on the ports for one cycle only.
module idle_connection_lru_timeout import ilt_pkg::*; #(
  parameter int unsigned MAX_CONN  = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              opcode_i,
  input  logic [CONN_ID_W-1:0]    conn_id_i,
  output logic                    busy_o,
  input  logic                    cfg_we_i,
  input  logic [IDLE_LIMIT_W-1:0] cfg_wdata_i,
  output logic                    close_valid_o,
  output logic [CONN_ID_W-1:0]    close_id_o,
  output logic                    last_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_CONN);
  localparam int unsigned PTR_W  = $clog2(MAX_CONN + 1);

  logic [IDLE_LIMIT_W-1:0] idle_limit_q;

  link_we_t          link_we;
  logic [ADDR_W-1:0] link_waddr;
  logic [PTR_W-1:0]  link_wnext;
  logic [PTR_W-1:0]  link_wprev;
  logic [ADDR_W-1:0] raddr;
  logic [PTR_W-1:0]  link_rnext;
  logic [PTR_W-1:0]  link_rprev;
  logic              stamp_we;
  logic [TIME_BITS-1:0] stamp_wdata;
  logic [TIME_BITS-1:0] stamp_rdata;

  // idle limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_limit_q <= IDLE_LIMIT_RST;
    end else if (cfg_we_i) begin
      idle_limit_q <= cfg_wdata_i;
    end
  end

  ilt_ctrl #(
    .MAX_CONN (MAX_CONN),
    .ADDR_W   (ADDR_W),
    .PTR_W    (PTR_W),
    .TIME_W   (TIME_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .opcode_i      (opcode_i),
    .conn_id_i     (conn_id_i),
    .busy_o        (busy_o),
    .idle_limit_i  (idle_limit_q),
    .link_we_o     (link_we),
    .link_waddr_o  (link_waddr),
    .link_wnext_o  (link_wnext),
    .link_wprev_o  (link_wprev),
    .raddr_o       (raddr),
    .link_rnext_i  (link_rnext),
    .link_rprev_i  (link_rprev),
    .stamp_we_o    (stamp_we),
    .stamp_wdata_o (stamp_wdata),
    .stamp_rdata_i (stamp_rdata),
    .close_valid_o (close_valid_o),
    .close_id_o    (close_id_o),
    .last_o        (last_o)
  );

  ilt_link_mem #(
    .DEPTH  (MAX_CONN),
    .ADDR_W (ADDR_W),
    .PTR_W  (PTR_W)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wnext_i (link_wnext),
    .wprev_i (link_wprev),
    .raddr_i (raddr),
    .rnext_o (link_rnext),
    .rprev_o (link_rprev)
  );

  ilt_stamp_mem #(
    .DEPTH  (MAX_CONN),
    .ADDR_W (ADDR_W),
    .TIME_W (TIME_BITS)
  ) u_stamp_mem (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (link_waddr),
    .wdata_i (stamp_wdata),
    .raddr_i (raddr),
    .rdata_o (stamp_rdata)
  );

endmodule
